// File: rtl/timed_event_queue_macros.svh
// ---------------------------------------------------------------------------
// Timed event queue assertion macros
// Shared concurrent assertion forms for the timed event queue.
// ---------------------------------------------------------------------------
`ifndef TIMED_EVENT_QUEUE_MACROS_SVH
`define TIMED_EVENT_QUEUE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define TEQ_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("timed event queue check failed");

// Next-cycle implication, checked outside reset
`define TEQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("timed event queue check failed");

`endif

// File: rtl/teq_pkg.sv
// ---------------------------------------------------------------------------
// Timed event queue package
// Sizes, result and operation codes, and the types shared by the queue cells.
// ---------------------------------------------------------------------------
package teq_pkg;

   // Table size and per-advance fire limit
   localparam int QUEUE_DEPTH = 16;
   localparam int MAX_RESULTS = 16;

   // Field widths
   localparam int TIME_W  = 32;
   localparam int ID_W    = 16;
   localparam int OP_W    = 2;
   localparam int KIND_W  = 3;
   localparam int RCNT_W  = 5;
   localparam int REM_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int FIRE_W  = $clog2(MAX_RESULTS + 1);
   localparam int RCNT_SAT = 31;

   // Request operations
   localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
   localparam logic [OP_W-1:0] OP_BATCH_ADD = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE    = 2'd2;
   localparam logic [OP_W-1:0] OP_ADVANCE   = 2'd3;

   // Result kinds
   localparam logic [KIND_W-1:0] KIND_FIRED    = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ADDED    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_PAST     = 3'd3;
   localparam logic [KIND_W-1:0] KIND_REMOVED  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NONE_DUE = 3'd5;

   // One table slot
   typedef struct packed {
      logic              valid;
      logic [TIME_W-1:0] time_val;
      logic [ID_W-1:0]   id;
   } entry_type;

   // What every cell does this cycle
   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_SQUEEZE,
      CELL_POP
   } cell_op_type;

   typedef struct packed {
      cell_op_type       op;
      logic [TIME_W-1:0] key;
      logic [ID_W-1:0]   id;
   } cell_cmd_type;

   // Chain view seen by the controller
   typedef struct packed {
      entry_type head;
      entry_type second;
      logic      full;
      logic      any_eq;
   } chain_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_ADVANCE
   } state_type;

endpackage

// File: rtl/timed_event_queue.sv
// ---------------------------------------------------------------------------
// Timed event queue
// Time-sorted event table with a current time; add, batch add, remove, advance.
// ---------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every result shows
// on the rsp_ ports for one cycle with rsp_strobe high, in the cycle after
// the step that makes it, and cannot be stalled; rsp_last_flag marks the
// final result of a request. An add or batch add gives one result. A remove
// gives one result once the row of cells has squeezed out every matching
// entry, one match per cycle. An advance gives one result per fired event,
// or a single none-due result; fired events leave the head cell one per
// cycle.
`include "timed_event_queue_macros.svh"

module timed_event_queue (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [teq_pkg::OP_W-1:0]            req_operation,
   input  logic [teq_pkg::TIME_W-1:0]          req_time_value,
   input  logic [teq_pkg::ID_W-1:0]            req_event_id,
   output logic                                rsp_strobe,
   output logic [teq_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [teq_pkg::ID_W-1:0]            rsp_fired_id,
   output logic [teq_pkg::TIME_W-1:0]          rsp_fired_time,
   output logic [teq_pkg::RCNT_W-1:0]          rsp_removed_count,
   output logic                                rsp_last_flag
);

   teq_pkg::state_type               state_ff, state_in;
   logic [teq_pkg::TIME_W-1:0]       cur_time_ff, cur_time_in;
   logic [teq_pkg::TIME_W-1:0]       key_ff, key_in;
   logic [teq_pkg::REM_W-1:0]        rm_cnt_ff, rm_cnt_in;
   logic [teq_pkg::FIRE_W-1:0]       fire_cnt_ff, fire_cnt_in;
   logic                             strobe_ff, strobe_in;
   logic [teq_pkg::KIND_W-1:0]       kind_ff, kind_in;
   logic [teq_pkg::ID_W-1:0]         fid_ff, fid_in;
   logic [teq_pkg::TIME_W-1:0]       ftime_ff, ftime_in;
   logic [teq_pkg::RCNT_W-1:0]       rcnt_ff, rcnt_in;
   logic                             last_ff, last_in;
   teq_pkg::cell_cmd_type            cmd;
   teq_pkg::chain_status_type        status;
   logic                             accept;
   logic                             past;
   logic [teq_pkg::TIME_W:0]         sum;
   logic [teq_pkg::TIME_W-1:0]       target;
   logic                             head_due;
   logic                             more_due;

   assign busy   = (state_ff != teq_pkg::ST_IDLE);
   assign accept = start && !busy;

   // Saturating advance target
   assign sum    = {1'b0, cur_time_ff} + {1'b0, req_time_value};
   assign target = sum[teq_pkg::TIME_W] ? '1 : sum[teq_pkg::TIME_W-1:0];

   // Past check differs between plain and batch add
   assign past = (req_operation == teq_pkg::OP_ADD) ? (req_time_value < cur_time_ff)
                                                    : (req_time_value <= cur_time_ff);

   // Head events due at the advance target
   assign head_due = status.head.valid && (status.head.time_val <= key_ff) &&
                     (fire_cnt_ff < teq_pkg::FIRE_W'(teq_pkg::MAX_RESULTS));
   assign more_due = status.second.valid && (status.second.time_val <= key_ff) &&
                     (fire_cnt_ff < teq_pkg::FIRE_W'(teq_pkg::MAX_RESULTS - 1));

   teq_chain u_chain (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (status)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (accept && req_operation == teq_pkg::OP_REMOVE) begin
               state_in = teq_pkg::ST_REMOVE;
            end else if (accept && req_operation == teq_pkg::OP_ADVANCE) begin
               state_in = teq_pkg::ST_ADVANCE;
            end
         end
         teq_pkg::ST_REMOVE: begin
            if (!status.any_eq) begin
               state_in = teq_pkg::ST_IDLE;
            end
         end
         teq_pkg::ST_ADVANCE: begin
            if (!head_due || !more_due) begin
               state_in = teq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = teq_pkg::ST_IDLE;
         end
      endcase
   end

   // Cell commands, counters and results
   always_comb begin
      cmd.op      = teq_pkg::CELL_HOLD;
      cmd.key     = busy ? key_ff : req_time_value;
      cmd.id      = req_event_id;
      cur_time_in = cur_time_ff;
      key_in      = key_ff;
      rm_cnt_in   = rm_cnt_ff;
      fire_cnt_in = fire_cnt_ff;
      strobe_in   = 1'b0;
      kind_in     = teq_pkg::KIND_ADDED;
      fid_in      = '0;
      ftime_in    = '0;
      rcnt_in     = '0;
      last_in     = 1'b0;
      case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_operation)
                  teq_pkg::OP_ADD, teq_pkg::OP_BATCH_ADD: begin
                     strobe_in = 1'b1;
                     last_in   = 1'b1;
                     if (past) begin
                        kind_in = teq_pkg::KIND_PAST;
                     end else if (status.full) begin
                        kind_in = teq_pkg::KIND_FULL;
                     end else begin
                        kind_in = teq_pkg::KIND_ADDED;
                        cmd.op  = teq_pkg::CELL_INSERT;
                     end
                  end
                  teq_pkg::OP_REMOVE: begin
                     key_in    = req_time_value;
                     rm_cnt_in = '0;
                  end
                  default: begin
                     key_in      = target;
                     cur_time_in = target;
                     fire_cnt_in = '0;
                  end
               endcase
            end
         end
         teq_pkg::ST_REMOVE: begin
            if (status.any_eq) begin
               cmd.op    = teq_pkg::CELL_SQUEEZE;
               rm_cnt_in = rm_cnt_ff + teq_pkg::REM_W'(1);
            end else begin
               strobe_in = 1'b1;
               last_in   = 1'b1;
               kind_in   = teq_pkg::KIND_REMOVED;
               rcnt_in   = (int'(rm_cnt_ff) > teq_pkg::RCNT_SAT)
                           ? teq_pkg::RCNT_W'(teq_pkg::RCNT_SAT)
                           : teq_pkg::RCNT_W'(rm_cnt_ff);
            end
         end
         teq_pkg::ST_ADVANCE: begin
            strobe_in = 1'b1;
            if (head_due) begin
               cmd.op      = teq_pkg::CELL_POP;
               fire_cnt_in = fire_cnt_ff + teq_pkg::FIRE_W'(1);
               kind_in     = teq_pkg::KIND_FIRED;
               fid_in      = status.head.id;
               ftime_in    = status.head.time_val;
               last_in     = !more_due;
            end else begin
               kind_in = teq_pkg::KIND_NONE_DUE;
               last_in = 1'b1;
            end
         end
         default: begin
            strobe_in = 1'b0;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= teq_pkg::ST_IDLE;
         cur_time_ff <= '0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cur_time_ff <= cur_time_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Working and result payload registers
   always_ff @(posedge clock) begin
      key_ff      <= key_in;
      rm_cnt_ff   <= rm_cnt_in;
      fire_cnt_ff <= fire_cnt_in;
      kind_ff     <= kind_in;
      fid_ff      <= fid_in;
      ftime_ff    <= ftime_in;
      rcnt_ff     <= rcnt_in;
      last_ff     <= last_in;
   end

   assign rsp_strobe        = strobe_ff;
   assign rsp_result_kind   = kind_ff;
   assign rsp_fired_id      = fid_ff;
   assign rsp_fired_time    = ftime_ff;
   assign rsp_removed_count = rcnt_ff;
   assign rsp_last_flag     = last_ff;

   // Only an advance gives more than one result per request
   `TEQ_ASSERT_IMPLY(a_multi_only_advance, clock, reset, strobe_ff && !last_ff, state_ff == teq_pkg::ST_ADVANCE && kind_ff == teq_pkg::KIND_FIRED)

   // An accepted add answers in the next cycle
   `TEQ_ASSERT_NEXT(a_add_answers, clock, reset, accept && (req_operation == teq_pkg::OP_ADD || req_operation == teq_pkg::OP_BATCH_ADD), strobe_ff && last_ff && state_ff == teq_pkg::ST_IDLE)

   // A full table never takes an insert
   `TEQ_ASSERT_IMPLY(a_no_insert_full, clock, reset, status.full, cmd.op != teq_pkg::CELL_INSERT)

   // Current time never moves backward
   `TEQ_ASSERT_NEXT(a_time_monotonic, clock, reset, 1'b1, cur_time_ff >= $past(cur_time_ff))

endmodule

// File: rtl/teq_cell.sv
// ---------------------------------------------------------------------------
// Timed event queue cell
// One slot of the sorted table; inserts, squeezes out or pops toward its
// neighbors under a command broadcast to the whole row.
// ---------------------------------------------------------------------------
module teq_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  teq_pkg::cell_cmd_type cmd,
   input  teq_pkg::entry_type    left_entry,
   input  logic                  left_le,
   input  teq_pkg::entry_type    right_entry,
   output teq_pkg::entry_type    entry,
   output logic                  le,
   output logic                  eq
);

   teq_pkg::entry_type entry_ff;
   teq_pkg::entry_type entry_in;
   logic               ge;

   // Compare own time against the broadcast key
   assign le = entry_ff.valid && (entry_ff.time_val <= cmd.key);
   assign ge = !entry_ff.valid || (entry_ff.time_val >= cmd.key);
   assign eq = entry_ff.valid && (entry_ff.time_val == cmd.key);

   // Pick the next slot contents
   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         teq_pkg::CELL_INSERT: begin
            if (!le) begin
               if (left_le) begin
                  entry_in.valid    = 1'b1;
                  entry_in.time_val = cmd.key;
                  entry_in.id       = cmd.id;
               end else begin
                  entry_in = left_entry;
               end
            end
         end
         teq_pkg::CELL_SQUEEZE: begin
            if (ge) begin
               entry_in = right_entry;
            end
         end
         teq_pkg::CELL_POP: begin
            entry_in = right_entry;
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   // Valid resets, payload follows
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff.valid <= entry_in.valid;
      end
      entry_ff.time_val <= entry_in.time_val;
      entry_ff.id       <= entry_in.id;
   end

   assign entry = entry_ff;

endmodule

// File: rtl/teq_chain.sv
// ---------------------------------------------------------------------------
// Timed event queue chain
// Row of cells kept in time order, head at slot zero.
// ---------------------------------------------------------------------------
module teq_chain (
   input  logic                      clock,
   input  logic                      reset,
   input  teq_pkg::cell_cmd_type     cmd,
   output teq_pkg::chain_status_type status
);

   teq_pkg::entry_type              entries [teq_pkg::QUEUE_DEPTH];
   teq_pkg::entry_type              lefts   [teq_pkg::QUEUE_DEPTH];
   teq_pkg::entry_type              rights  [teq_pkg::QUEUE_DEPTH];
   logic [teq_pkg::QUEUE_DEPTH-1:0] le_vec;
   logic [teq_pkg::QUEUE_DEPTH-1:0] left_le_vec;
   logic [teq_pkg::QUEUE_DEPTH-1:0] eq_vec;

   // Wire each cell to its neighbors; the ends see an empty slot
   for (genvar i = 0; i < teq_pkg::QUEUE_DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign lefts[i]       = '0;
         assign left_le_vec[i] = 1'b1;
      end else begin : g_inner
         assign lefts[i]       = entries[i-1];
         assign left_le_vec[i] = le_vec[i-1];
      end
      if (i == teq_pkg::QUEUE_DEPTH - 1) begin : g_last
         assign rights[i] = '0;
      end else begin : g_body
         assign rights[i] = entries[i+1];
      end

      teq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .left_entry  (lefts[i]),
         .left_le     (left_le_vec[i]),
         .right_entry (rights[i]),
         .entry       (entries[i]),
         .le          (le_vec[i]),
         .eq          (eq_vec[i])
      );
   end

   // Report the head pair, fill and match
   assign status.head   = entries[0];
   assign status.second = entries[1];
   assign status.full   = entries[teq_pkg::QUEUE_DEPTH-1].valid;
   assign status.any_eq = |eq_vec;

endmodule
